### rtl/link_ping_rtt_loss_monitor_assert.svh
// assertion macros for the link probe
// clocked on clk, disabled while rst is high; no other dependencies
`ifndef LINK_PING_RTT_LOSS_MONITOR_ASSERT_SVH
`define LINK_PING_RTT_LOSS_MONITOR_ASSERT_SVH

// same-cycle implication
`define LPRLM_ASSERT(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define LPRLM_ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/lprlm_pkg.sv
// shared constants and types of the link probe
// no dependencies
package lprlm_pkg;

  localparam int CFG_ADDR_W = 8;
  localparam int FRAME_ID_W = 16;
  localparam int SLOT_W     = 48;
  localparam int PROD_W     = 42;
  localparam int LOSS_W     = 10;

  // command and result codes
  localparam logic CMD_POLL     = 1'b0;
  localparam logic CMD_FRAME    = 1'b1;
  localparam logic KIND_PING    = 1'b0;
  localparam logic KIND_METRICS = 1'b1;

  // register indexes
  localparam logic [CFG_ADDR_W-1:0] REG_PING_INTERVAL = 8'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_WINDOW_LENGTH = 8'd1;

  localparam logic [15:0] PING_INTERVAL_RST = 16'd100;
  localparam logic [31:0] WINDOW_LENGTH_RST = 32'd2000;

  localparam logic [7:0]  PONG_TYPE     = 8'h11;
  localparam logic [15:0] FREE_ID       = 16'hFFFF;
  localparam logic [15:0] MIN_FRAME_LEN = 16'd3;
  localparam logic [9:0]  LOSS_SCALE    = 10'd1000;

  // divider step counts
  localparam logic [5:0] DIV_STEPS_LOSS = 6'd10;
  localparam logic [5:0] DIV_STEPS_AVG  = 6'd32;

  typedef struct packed {
    logic       start;
    logic [5:0] steps;
  } div_ctl_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_sts_t;

endpackage

### rtl/lprlm_in_if.sv
// input channel of the link probe: poll or received frame
// no dependencies
interface lprlm_in_if;
  logic        valid;
  logic        ready;
  logic        command;
  logic [31:0] time_ms;
  logic [7:0]  frame_type;
  logic [15:0] frame_id;
  logic [15:0] frame_length;

  modport source (output valid, command, time_ms, frame_type, frame_id, frame_length,
                  input ready);
  modport sink (input valid, command, time_ms, frame_type, frame_id, frame_length,
                output ready);
endinterface

### rtl/lprlm_out_if.sv
// result channel of the link probe: ping requests and window metrics
// no dependencies
interface lprlm_out_if;
  logic        valid;
  logic        ready;
  logic        result_kind;
  logic [15:0] ping_id;
  logic [15:0] avg_rtt_ms;
  logic [9:0]  loss_rate;
  logic        last_result;

  modport source (output valid, result_kind, ping_id, avg_rtt_ms, loss_rate,
                  last_result, input ready);
  modport sink (input valid, result_kind, ping_id, avg_rtt_ms, loss_rate,
                last_result, output ready);
endinterface

### rtl/lprlm_cfg_if.sv
// register write channel of the link probe
// depends on lprlm_pkg for the index width
interface lprlm_cfg_if;
  import lprlm_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [CFG_ADDR_W-1:0] addr;
  logic [31:0]           data;

  modport source (output valid, addr, data, input ready);
  modport sink (input valid, addr, data, output ready);
endinterface

### rtl/link_ping_rtt_loss_monitor.sv
// link probe: ping issue, pong matching, windowed loss and average rtt
// one item at a time; a pong frame runs a 16-step serial slot modulo, then a ram read and the match
// a poll runs the ping check, plus with window metrics a 10-step loss division
// and a 32-step average division on the shared bit-serial divider
// a result still held on the output stalls the ping and metrics steps until taken
// rst is synchronous: registers to reset values, all slots read as free, no output
`include "link_ping_rtt_loss_monitor_assert.svh"

module link_ping_rtt_loss_monitor #(
  parameter int TABLE_DEPTH = 16
) (
  input logic          clk,
  input logic          rst,
  lprlm_in_if.sink     req,
  lprlm_out_if.source  rsp,
  lprlm_cfg_if.sink    cfg
);
  import lprlm_pkg::*;

  localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam logic [IDX_W:0]   DEPTH_C   = (IDX_W + 1)'(TABLE_DEPTH);
  localparam logic [IDX_W-1:0] LAST_SLOT = IDX_W'(TABLE_DEPTH - 1);
  localparam logic [3:0]       MOD_LAST  = 4'(FRAME_ID_W - 1);

  typedef enum logic [3:0] {
    S_IDLE, S_CHECK, S_PING, S_LOST, S_LOSS_GO, S_LOSS_WAIT,
    S_AVG_GO, S_AVG_WAIT, S_METRICS, S_MOD, S_READ, S_MATCH
  } state_t;

  state_t state;

  // registers
  logic [15:0]            ping_interval;
  logic [31:0]            window_length;
  logic [31:0]            now_q;
  logic [15:0]            fid_q;
  logic                   ping_due;
  logic                   win_due;
  logic [15:0]            next_id;
  logic [IDX_W-1:0]       next_slot;
  logic [31:0]            pings_sent;
  logic [31:0]            pongs_received;
  logic [31:0]            rtt_sum;
  logic [31:0]            window_start;
  logic [31:0]            last_ping_time;
  logic [TABLE_DEPTH-1:0] slot_valid;
  logic [31:0]            lost;
  logic [LOSS_W-1:0]      loss_q;
  logic [15:0]            avg_q;
  logic [IDX_W-1:0]       mod_rem;
  logic [3:0]             mod_cnt;
  logic [15:0]            mod_sh;
  logic                   out_valid;
  logic                   out_kind;
  logic [15:0]            out_id;
  logic [15:0]            out_avg;
  logic [LOSS_W-1:0]      out_loss;
  logic                   out_last;

  // combinational
  logic                   out_free;
  logic                   out_load;
  logic [IDX_W:0]         mod_shifted;
  logic [IDX_W-1:0]       mod_rem_next;
  logic [IDX_W-1:0]       next_slot_next;
  logic [PROD_W-1:0]      prod;
  logic                   ram_we;
  logic [IDX_W-1:0]       ram_waddr;
  logic [SLOT_W-1:0]      ram_wdata;
  logic [SLOT_W-1:0]      ram_rdata;
  logic [15:0]            eff_id;
  logic [31:0]            eff_time;
  logic                   pong_hit;
  div_ctl_t               div_ctl;
  div_sts_t               div_sts;
  logic [31:0]            div_rem_init;
  logic [31:0]            div_num_init;
  logic [31:0]            div_divisor;
  logic [31:0]            div_quo;
  logic                   ping_out;
  logic                   metrics_out;
  logic                   div_waiting;

  assign out_free = !out_valid || rsp.ready;
  assign req.ready = (state == S_IDLE);
  assign cfg.ready = 1'b1;

  // a result is loaded when the ping or metrics step finds the output free
  assign out_load = out_free && ((state == S_PING && ping_due) || state == S_METRICS);

  // one step of the serial id modulo table depth
  assign mod_shifted  = {mod_rem, mod_sh[15]};
  assign mod_rem_next = (mod_shifted >= DEPTH_C) ? IDX_W'(mod_shifted - DEPTH_C)
                                                 : mod_shifted[IDX_W-1:0];

  // ping slot follows next_id modulo depth, restarting when the id wraps
  assign next_slot_next = ((next_id == FREE_ID) || (next_slot == LAST_SLOT))
                          ? '0 : IDX_W'(next_slot + 1'b1);

  // slot contents, free reading as reset values
  assign eff_id   = slot_valid[mod_rem] ? ram_rdata[47:32] : FREE_ID;
  assign eff_time = slot_valid[mod_rem] ? ram_rdata[31:0] : 32'd0;
  assign pong_hit = (eff_id == fid_q);

  // slot table writes: ping fill or pong release
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = next_slot;
    ram_wdata = {next_id, now_q};
    if (state == S_PING && ping_due && out_free) begin
      ram_we = 1'b1;
    end else if (state == S_MATCH && pong_hit) begin
      ram_we    = 1'b1;
      ram_waddr = mod_rem;
      ram_wdata = {FREE_ID, eff_time};
    end
  end

  lprlm_ram #(.WIDTH(SLOT_W), .DEPTH(TABLE_DEPTH)) u_slots (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (mod_rem),
    .rdata (ram_rdata)
  );

  // divider request: loss uses lost*1000 with the high part preloaded
  assign prod = PROD_W'(lost) * PROD_W'(LOSS_SCALE);

  always_comb begin
    div_ctl.start = 1'b0;
    div_ctl.steps = DIV_STEPS_AVG;
    div_rem_init  = '0;
    div_num_init  = rtt_sum;
    div_divisor   = pongs_received;
    if (state == S_LOSS_GO) begin
      div_ctl.start = (pings_sent != 32'd0);
      div_ctl.steps = DIV_STEPS_LOSS;
      div_rem_init  = prod[PROD_W-1:LOSS_W];
      div_num_init  = {prod[LOSS_W-1:0], (32 - LOSS_W)'(0)};
      div_divisor   = pings_sent;
    end else if (state == S_AVG_GO) begin
      div_ctl.start = (pongs_received != 32'd0);
    end
  end

  lprlm_div u_div (
    .clk      (clk),
    .rst      (rst),
    .ctl      (div_ctl),
    .rem_init (div_rem_init),
    .num_init (div_num_init),
    .divisor  (div_divisor),
    .sts      (div_sts),
    .quo      (div_quo)
  );

  // sequencer, counters and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= S_IDLE;
      ping_interval  <= PING_INTERVAL_RST;
      window_length  <= WINDOW_LENGTH_RST;
      next_id        <= '0;
      next_slot      <= '0;
      pings_sent     <= '0;
      pongs_received <= '0;
      rtt_sum        <= '0;
      window_start   <= '0;
      last_ping_time <= '0;
      slot_valid     <= '0;
      out_valid      <= 1'b0;
    end else begin
      // register writes
      if (cfg.valid) begin
        unique case (cfg.addr)
          REG_PING_INTERVAL: ping_interval <= cfg.data[15:0];
          REG_WINDOW_LENGTH: window_length <= cfg.data;
          default: ;
        endcase
      end

      // output valid: a new result replaces one taken in the same cycle
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (rsp.ready) begin
        out_valid <= 1'b0;
      end

      unique case (state)
        S_IDLE: begin
          if (req.valid) begin
            now_q   <= req.time_ms;
            fid_q   <= req.frame_id;
            mod_sh  <= req.frame_id;
            mod_rem <= '0;
            mod_cnt <= '0;
            if (req.command == CMD_FRAME) begin
              if (req.frame_length >= MIN_FRAME_LEN && req.frame_type == PONG_TYPE) begin
                state <= S_MOD;
              end
            end else begin
              state <= S_CHECK;
            end
          end
        end
        S_CHECK: begin
          ping_due <= ((now_q - last_ping_time) >= {16'd0, ping_interval});
          win_due  <= ((now_q - window_start) >= window_length);
          state    <= S_PING;
        end
        S_PING: begin
          if (!ping_due) begin
            state <= win_due ? S_LOST : S_IDLE;
          end else if (out_free) begin
            slot_valid[next_slot] <= 1'b1;
            next_id        <= next_id + 16'd1;
            next_slot      <= next_slot_next;
            pings_sent     <= pings_sent + 32'd1;
            last_ping_time <= now_q;
            out_kind       <= KIND_PING;
            out_id         <= next_id;
            out_avg        <= '0;
            out_loss       <= '0;
            out_last       <= !win_due;
            state          <= win_due ? S_LOST : S_IDLE;
          end
        end
        S_LOST: begin
          lost  <= (pings_sent > pongs_received) ? (pings_sent - pongs_received) : 32'd0;
          state <= S_LOSS_GO;
        end
        S_LOSS_GO: begin
          if (pings_sent == 32'd0) begin
            loss_q <= '0;
            state  <= S_AVG_GO;
          end else begin
            state <= S_LOSS_WAIT;
          end
        end
        S_LOSS_WAIT: begin
          if (div_sts.done) begin
            loss_q <= div_quo[LOSS_W-1:0];
            state  <= S_AVG_GO;
          end
        end
        S_AVG_GO: begin
          if (pongs_received == 32'd0) begin
            avg_q <= '0;
            state <= S_METRICS;
          end else begin
            state <= S_AVG_WAIT;
          end
        end
        S_AVG_WAIT: begin
          if (div_sts.done) begin
            avg_q <= div_quo[15:0];
            state <= S_METRICS;
          end
        end
        S_METRICS: begin
          if (out_free) begin
            out_kind       <= KIND_METRICS;
            out_id         <= '0;
            out_avg        <= avg_q;
            out_loss       <= loss_q;
            out_last       <= 1'b1;
            window_start   <= now_q;
            pings_sent     <= '0;
            pongs_received <= '0;
            rtt_sum        <= '0;
            state          <= S_IDLE;
          end
        end
        S_MOD: begin
          mod_rem <= mod_rem_next;
          mod_sh  <= {mod_sh[14:0], 1'b0};
          mod_cnt <= mod_cnt + 4'd1;
          if (mod_cnt == MOD_LAST) begin
            state <= S_READ;
          end
        end
        S_READ: begin
          state <= S_MATCH;
        end
        S_MATCH: begin
          if (pong_hit) begin
            rtt_sum               <= rtt_sum + (now_q - eff_time);
            pongs_received        <= pongs_received + 32'd1;
            slot_valid[mod_rem]   <= 1'b1;
          end
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // output port
  assign rsp.valid       = out_valid;
  assign rsp.result_kind = out_kind;
  assign rsp.ping_id     = out_id;
  assign rsp.avg_rtt_ms  = out_avg;
  assign rsp.loss_rate   = out_loss;
  assign rsp.last_result = out_last;

  // checks
  assign ping_out    = out_valid && (out_kind == KIND_PING);
  assign metrics_out = out_valid && (out_kind == KIND_METRICS);
  assign div_waiting = (state == S_LOSS_WAIT) || (state == S_AVG_WAIT);

  `LPRLM_ASSERT(a_div_idle_start, div_ctl.start, !div_sts.busy, "divider restarted while busy")
  `LPRLM_ASSERT(a_div_done_wait, div_sts.done, div_waiting, "divider result with no waiting step")
  `LPRLM_ASSERT(a_ping_id_seq, ping_out, out_id + 16'd1 == next_id, "ping id out of sequence")
  `LPRLM_ASSERT(a_loss_range, metrics_out, out_loss <= LOSS_SCALE, "loss above one thousand")
  `LPRLM_ASSERT_NEXT(a_div_run, div_ctl.start, div_sts.busy, "division not started")

endmodule

### rtl/lprlm_ram.sv
// generic single-write, single-read ram with registered read data
// no dependencies
module lprlm_ram #(
  parameter int WIDTH = 48,
  parameter int DEPTH = 16
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  // write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

### rtl/lprlm_div.sv
// bit-serial restoring divider, one quotient bit per cycle
// depends on lprlm_pkg for the control and status structs
module lprlm_div (
  input  logic                clk,
  input  logic                rst,
  input  lprlm_pkg::div_ctl_t ctl,
  input  logic [31:0]         rem_init,
  input  logic [31:0]         num_init,
  input  logic [31:0]         divisor,
  output lprlm_pkg::div_sts_t sts,
  output logic [31:0]         quo
);
  import lprlm_pkg::*;

  logic        busy;
  logic        done;
  logic [5:0]  cnt;
  logic [31:0] rem;
  logic [31:0] num;
  logic [31:0] dvs;
  logic [32:0] shifted;
  logic        q_bit;

  // one trial subtraction
  assign shifted = {rem, num[31]};
  assign q_bit   = (shifted >= {1'b0, dvs});

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (ctl.start) begin
        busy <= 1'b1;
        cnt  <= ctl.steps;
        rem  <= rem_init;
        num  <= num_init;
        dvs  <= divisor;
      end else if (busy) begin
        rem <= q_bit ? 32'(shifted - {1'b0, dvs}) : shifted[31:0];
        num <= {num[30:0], q_bit};
        cnt <= cnt - 6'd1;
        if (cnt == 6'd1) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign sts.busy = busy;
  assign sts.done = done;
  assign quo      = num;
endmodule
